// File: hdl/fcd_pkg.sv
// Shared types, codes and constants of the fader calibrator.
package fcd_pkg;

   localparam int DEF_CHANNELS = 8;
   localparam int CH_W         = 3;
   localparam int MAX_LANES    = 2 ** CH_W;
   localparam int ACT_W        = 4;
   localparam int LEVEL_W      = 10;
   localparam int DVD_W        = 2 * LEVEL_W;
   localparam int DATA_W       = 32;
   localparam int ADDR_W       = 3;

   localparam logic [LEVEL_W-1:0] FULL_SCALE = 10'd1023;
   localparam logic [LEVEL_W-1:0] DEADBAND   = 10'd3;

   typedef enum logic [1:0] {
      ACT_SAMPLE    = 2'd0,
      ACT_LINK_LOST = 2'd1,
      ACT_SYNC      = 2'd2,
      ACT_UNUSED    = 2'd3
   } action_type;

   typedef enum logic {
      KIND_UPDATE = 1'b0,
      KIND_COMMIT = 1'b1
   } kind_type;

   typedef enum logic {
      REG_MIN_RANGE = 1'b0,
      REG_MAX_RANGE = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_CHECK,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [1:0]         action;
      logic               link_up;
      logic [CH_W-1:0]    channel;
      logic [ACT_W-1:0]   frame_length;
      logic [LEVEL_W-1:0] raw_value;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic [CH_W-1:0]    out_channel;
      logic [LEVEL_W-1:0] volume;
      logic               last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] min_range;
      logic [LEVEL_W-1:0] max_range;
   } cfg_type;

   typedef struct packed {
      logic               start;
      logic [DVD_W-1:0]   dividend;
      logic [LEVEL_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [LEVEL_W-1:0] quotient;
   } div_res_type;

endpackage

// File: hdl/fcd_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module fcd_divider (
   input  logic                clock,
   input  logic                reset,
   input  fcd_pkg::div_cmd_type cmd,
   output fcd_pkg::div_res_type res
);
   import fcd_pkg::*;

   localparam int QUO_W = LEVEL_W;
   localparam int CNT_W = $clog2(QUO_W);

   logic [LEVEL_W-1:0] rem_ff, rem_in;
   logic [LEVEL_W-1:0] dvd_ff, dvd_in;
   logic [LEVEL_W-1:0] den_ff, den_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   logic [LEVEL_W:0]   trial;
   logic [LEVEL_W+1:0] sub;
   logic               fits;

   // caller guarantees dividend < divisor * 2**QUO_W
   assign trial = {rem_ff, dvd_ff[LEVEL_W-1]};
   assign sub   = {1'b0, trial} - {2'b00, den_ff};
   assign fits  = !sub[LEVEL_W+1];

   always_comb begin
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (cmd.start) begin
         rem_in   = cmd.dividend[DVD_W-1:LEVEL_W];
         dvd_in   = cmd.dividend[LEVEL_W-1:0];
         den_in   = cmd.divisor;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? sub[LEVEL_W-1:0] : trial[LEVEL_W-1:0];
         dvd_in   = {dvd_ff[LEVEL_W-2:0], 1'b0};
         quo_in   = {quo_ff[QUO_W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign res.busy     = busy_ff;
   assign res.done     = done_ff;
   assign res.quotient = quo_ff;

endmodule

// File: hdl/fcd_csr.sv
// APB register block holding the calibration window.
module fcd_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [fcd_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [fcd_pkg::DATA_W-1:0] csr_pwdata,
   output logic [fcd_pkg::DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output fcd_pkg::cfg_type           cfg
);
   import fcd_pkg::*;

   logic [LEVEL_W-1:0] min_ff, min_in;
   logic [LEVEL_W-1:0] max_ff, max_in;
   logic               wr_en;
   reg_index_type      sel;

   // word aligned: only the register select bit is decoded
   assign sel   = reg_index_type'(csr_paddr[2]);
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      if (wr_en) begin
         case (sel)
            REG_MIN_RANGE: min_in = csr_pwdata[LEVEL_W-1:0];
            REG_MAX_RANGE: max_in = csr_pwdata[LEVEL_W-1:0];
            default:       min_in = min_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= '0;
         max_ff <= FULL_SCALE;
      end else begin
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

   always_comb begin
      case (sel)
         REG_MIN_RANGE: csr_prdata = DATA_W'(min_ff);
         REG_MAX_RANGE: csr_prdata = DATA_W'(max_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign csr_pready    = 1'b1;
   assign cfg.min_range = min_ff;
   assign cfg.max_range = max_ff;

endmodule

// File: hdl/fader_calibrate_deadband.sv
// Top level of the fader calibrator: frame tracking, deadband and sync commit.
//
// Takes one raw fader sample (or a link-lost clear, or a sync tick) per
// transaction and maps it through the [min_range, max_range] window onto
// 0..1023. Samples that clip go straight to the deadband check; samples
// inside the window first go through the serial divider (one quotient bit
// per cycle). A sync tick first scans every stored channel (one per cycle)
// to find the changed ones, then walks them again to emit and commit,
// stalling at a changed channel while the result side is not ready.
// Link-lost, ignored and unused-code transactions are handled in the idle
// state alone. req_ready is high only between transactions; a finished
// result sits in the output register and does not hold off the next
// request until another result needs that register.
module fader_calibrate_deadband #(
   parameter int CHANNELS = fcd_pkg::DEF_CHANNELS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  fcd_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output fcd_pkg::rsp_type           rsp_data,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [fcd_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [fcd_pkg::DATA_W-1:0] csr_pwdata,
   output logic [fcd_pkg::DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);
   import fcd_pkg::*;

   // only channels reachable through the 3-bit channel field get storage
   localparam int DEPTH = (CHANNELS < MAX_LANES) ? CHANNELS : MAX_LANES;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   cfg_type     cfg;
   div_cmd_type div_cmd;
   div_res_type div_res;

   fcd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   fcd_divider u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   // control state
   state_type          state_ff, state_in;
   logic [ACT_W-1:0]   active_ff, active_in;
   logic               accepted_ff, accepted_in;
   logic [DEPTH-1:0]   level_valid_ff, level_valid_in;
   logic [DEPTH-1:0]   committed_valid_ff, committed_valid_in;
   logic [DEPTH-1:0]   dirty_ff, dirty_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload state
   logic [LEVEL_W-1:0] level_value_ff [DEPTH];
   logic [LEVEL_W-1:0] committed_value_ff [DEPTH];
   logic [LEVEL_W-1:0] val_ff, val_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               level_we;
   logic               commit_we;

   logic               req_fire;
   logic               slot_free;
   logic               sample_live;
   logic               frame_start;
   logic [ACT_W-1:0]   flen_sat;
   logic               grow;
   logic [ACT_W-1:0]   act_now;
   logic               acc_now;
   logic               take_sample;
   logic               lo_clip;
   logic               hi_clip;
   logic [LEVEL_W-1:0] span;
   logic [DVD_W-1:0]   numer;
   logic [LEVEL_W-1:0] old_level;
   logic [LEVEL_W-1:0] dev;
   logic               in_band;
   logic               changed;
   logic               above;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // --- frame decision, evaluated on the incoming sample ---
   assign sample_live = (action_type'(req_data.action) == ACT_SAMPLE) && req_data.link_up;
   assign frame_start = sample_live && (req_data.channel == '0);
   assign flen_sat    = (32'(req_data.frame_length) > CHANNELS) ? ACT_W'(CHANNELS)
                                                               : req_data.frame_length;
   assign grow        = (active_ff == '0) || (active_ff < flen_sat);
   assign act_now     = (frame_start && grow) ? flen_sat : active_ff;
   assign acc_now     = frame_start ? (grow || (flen_sat == active_ff)) : accepted_ff;
   assign take_sample = sample_live && acc_now && (ACT_W'(req_data.channel) < act_now)
                        && (32'(req_data.channel) < DEPTH);

   // --- calibration window; an empty window clips at min_range+1 ---
   assign lo_clip = (req_data.raw_value <= cfg.min_range);
   assign hi_clip = (cfg.max_range <= cfg.min_range) || (req_data.raw_value >= cfg.max_range);
   assign span    = req_data.raw_value - cfg.min_range;
   // span * 1023 as a shift and subtract
   assign numer   = {span, {LEVEL_W{1'b0}}} - DVD_W'(span);

   // --- deadband against the stored level of the addressed channel ---
   assign old_level = level_value_ff[idx_ff];
   assign dev       = (old_level > val_ff) ? (old_level - val_ff) : (val_ff - old_level);
   assign in_band   = level_valid_ff[idx_ff] && (dev < DEADBAND);

   // --- sync: does this channel differ from its last commit ---
   assign changed = (ACT_W'(idx_ff) < active_ff) && level_valid_ff[idx_ff]
                    && !(committed_valid_ff[idx_ff]
                         && (committed_value_ff[idx_ff] == old_level));

   // any changed channel still ahead of the walk pointer
   always_comb begin
      above = 1'b0;
      for (int j = 0; j < DEPTH; j++) begin
         if (IDX_W'(j) > idx_ff) begin
            above = above | dirty_ff[j];
         end
      end
   end

   always_comb begin
      state_in           = state_ff;
      active_in          = active_ff;
      accepted_in        = accepted_ff;
      level_valid_in     = level_valid_ff;
      committed_valid_in = committed_valid_ff;
      dirty_in           = dirty_ff;
      idx_in             = idx_ff;
      val_in             = val_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_data_in        = rsp_data_ff;
      level_we           = 1'b0;
      commit_we          = 1'b0;
      div_cmd.start      = 1'b0;
      div_cmd.dividend   = numer;
      div_cmd.divisor    = cfg.max_range - cfg.min_range;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (action_type'(req_data.action))
                  ACT_SAMPLE: begin
                     if (sample_live) begin
                        active_in   = act_now;
                        accepted_in = acc_now;
                        if (frame_start && grow) begin
                           level_valid_in     = '0;
                           committed_valid_in = '0;
                        end
                     end
                     if (take_sample) begin
                        idx_in = req_data.channel[IDX_W-1:0];
                        if (lo_clip) begin
                           val_in   = '0;
                           state_in = ST_CHECK;
                        end else if (hi_clip) begin
                           val_in   = FULL_SCALE;
                           state_in = ST_CHECK;
                        end else begin
                           div_cmd.start = 1'b1;
                           state_in      = ST_DIVIDE;
                        end
                     end
                  end
                  ACT_LINK_LOST: begin
                     active_in          = '0;
                     accepted_in        = 1'b0;
                     level_valid_in     = '0;
                     committed_valid_in = '0;
                  end
                  ACT_SYNC: begin
                     idx_in   = '0;
                     dirty_in = '0;
                     state_in = ST_SCAN;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end

         ST_DIVIDE: begin
            if (div_res.done) begin
               val_in   = div_res.quotient;
               state_in = ST_CHECK;
            end
         end

         ST_CHECK: begin
            if (in_band) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               level_we                      = 1'b1;
               level_valid_in[idx_ff]        = 1'b1;
               rsp_valid_in                  = 1'b1;
               rsp_data_in.kind              = KIND_UPDATE;
               rsp_data_in.out_channel       = CH_W'(idx_ff);
               rsp_data_in.volume            = val_ff;
               rsp_data_in.last_of_run       = 1'b1;
               state_in                      = ST_IDLE;
            end
         end

         ST_SCAN: begin
            dirty_in[idx_ff] = changed;
            if (idx_ff == IDX_W'(DEPTH - 1)) begin
               idx_in   = '0;
               state_in = ST_EMIT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         ST_EMIT: begin
            if (!dirty_ff[idx_ff] || slot_free) begin
               if (dirty_ff[idx_ff]) begin
                  commit_we                  = 1'b1;
                  committed_valid_in[idx_ff] = 1'b1;
                  rsp_valid_in               = 1'b1;
                  rsp_data_in.kind           = KIND_COMMIT;
                  rsp_data_in.out_channel    = CH_W'(idx_ff);
                  rsp_data_in.volume         = old_level;
                  rsp_data_in.last_of_run    = !above;
               end
               if (idx_ff == IDX_W'(DEPTH - 1)) begin
                  idx_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         active_ff          <= '0;
         accepted_ff        <= 1'b0;
         level_valid_ff     <= '0;
         committed_valid_ff <= '0;
         dirty_ff           <= '0;
         idx_ff             <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         active_ff          <= active_in;
         accepted_ff        <= accepted_in;
         level_valid_ff     <= level_valid_in;
         committed_valid_ff <= committed_valid_in;
         dirty_ff           <= dirty_in;
         idx_ff             <= idx_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
      val_ff      <= val_in;
      rsp_data_ff <= rsp_data_in;
   end

   // level and commit stores, single write port each at the walk pointer
   always_ff @(posedge clock) begin
      if (level_we) begin
         level_value_ff[idx_ff] <= val_ff;
      end
      if (commit_we) begin
         committed_value_ff[idx_ff] <= old_level;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // --- checks ---
   // link loss forgets every channel and the frame size at once
   a_link_lost_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (action_type'(req_data.action) == ACT_LINK_LOST))
      |=> (level_valid_ff == '0 && committed_valid_ff == '0 && active_ff == '0))
      else $error("link-lost transaction left stored state behind");

   // the divider only runs on in-window samples, so it never reaches full scale
   a_quotient_range: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> (div_res.quotient < FULL_SCALE))
      else $error("divider quotient out of range");

   // the divider is only ever busy while the sequencer waits for it
   a_divider_owned: assert property (@(posedge clock) disable iff (reset)
      div_res.busy |-> (state_ff == ST_DIVIDE))
      else $error("divider busy outside divide state");

endmodule
